FILE: hw/rtl/owbm_pkg.sv
`default_nettype none

package owbm_pkg;

  localparam int TICK_W = 10;
  localparam int PHASE_W = 4;

  localparam int RESET_LOW_TICKS_DEF = 500;
  localparam int PRESENCE_SAMPLE_TICKS_DEF = 80;
  localparam int WRITE_SLOT_TICKS_DEF = 60;
  localparam int READ_RECOVER_TICKS_DEF = 120;

  localparam logic [TICK_W-1:0] RELEASE_CHECK_TICKS = TICK_W'(5);
  localparam logic [TICK_W-1:0] RESET_RECOVER_TICKS = TICK_W'(420);
  localparam logic [TICK_W-1:0] SLOT_LOW_TICKS = TICK_W'(2);
  localparam logic [TICK_W-1:0] WRITE_RELEASE_TICKS = TICK_W'(2);
  localparam logic [TICK_W-1:0] READ_SAMPLE_TICKS = TICK_W'(8);

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [1:0] STATUS_PRESENT = 2'd0;
  localparam logic [1:0] STATUS_STUCK = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  localparam logic [PHASE_W-1:0] PH_IDLE = 4'd0;
  localparam logic [PHASE_W-1:0] PH_RST_LOW = 4'd1;
  localparam logic [PHASE_W-1:0] PH_RST_REL = 4'd2;
  localparam logic [PHASE_W-1:0] PH_RST_PRES = 4'd3;
  localparam logic [PHASE_W-1:0] PH_RST_REC = 4'd4;
  localparam logic [PHASE_W-1:0] PH_WR_LOW = 4'd5;
  localparam logic [PHASE_W-1:0] PH_WR_HOLD = 4'd6;
  localparam logic [PHASE_W-1:0] PH_WR_REL = 4'd7;
  localparam logic [PHASE_W-1:0] PH_RD_LOW = 4'd8;
  localparam logic [PHASE_W-1:0] PH_RD_WAIT = 4'd9;
  localparam logic [PHASE_W-1:0] PH_RD_REC = 4'd10;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_result;
    logic       rejected;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/one_wire_bus_master_core.sv
`default_nettype none

// Single-wire bus master timed in microsecond ticks: each input item is one tick carrying the
// sampled line level and, on an idle tick, an optional command (reset with presence check,
// write byte LSB first, read byte). Every item yields exactly one result item giving the line
// drive, busy, done, reset status, last read byte and a rejected flag for a command that
// arrived while busy. An item is accepted every cycle while the skid entry is empty; its result
// is computed in one pass from the phase registers and goes to the two-entry output buffer: the
// output register, or the skid entry if the output stalls, so the input takes one more item.
module one_wire_bus_master_core
  import owbm_pkg::*;
#(
  parameter int RESET_LOW_TICKS = RESET_LOW_TICKS_DEF,
  parameter int PRESENCE_SAMPLE_TICKS = PRESENCE_SAMPLE_TICKS_DEF,
  parameter int WRITE_SLOT_TICKS = WRITE_SLOT_TICKS_DEF,
  parameter int READ_RECOVER_TICKS = READ_RECOVER_TICKS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_write_byte,
  input  wire logic       in_line_level,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_drive_low,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic [1:0]      out_status,
  output logic [7:0]      out_read_result,
  output logic            out_rejected
);

  localparam logic [TICK_W-1:0] RST_LOW_LEN = TICK_W'(RESET_LOW_TICKS);
  localparam logic [TICK_W-1:0] PRES_LEN = TICK_W'(PRESENCE_SAMPLE_TICKS);
  localparam logic [TICK_W-1:0] WR_SLOT_LEN = TICK_W'(WRITE_SLOT_TICKS);
  localparam logic [TICK_W-1:0] RD_REC_LEN = TICK_W'(READ_RECOVER_TICKS);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [2:0]         bit_r, bit_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [7:0]         rdreg_r, rdreg_nxt;

  res_t res;
  res_t main_r, skid_r;
  logic out_valid_r, skid_valid_r;
  logic accept;

  logic [PHASE_W-1:0] ph;
  logic [TICK_W-1:0]  tick_wrap;
  logic [TICK_W-1:0]  seg_len;
  logic               seg_end;

  assign in_ready = !skid_valid_r;
  assign accept = in_valid && in_ready;

  always_comb begin
    ph = phase_r;
    bit_nxt = bit_r;
    shift_nxt = shift_r;
    tick_nxt = tick_r;
    status_nxt = status_r;
    rdreg_nxt = rdreg_r;
    res = '0;

    if (phase_r != PH_IDLE) begin
      res.rejected = (in_command != CMD_NONE);
    end else if (in_command != CMD_NONE) begin
      bit_nxt = 3'd0;
      tick_nxt = '0;
      case (in_command)
        CMD_RESET: ph = PH_RST_LOW;
        CMD_WRITE: begin
          ph = PH_WR_LOW;
          shift_nxt = in_write_byte;
        end
        default: begin
          ph = PH_RD_LOW;
          shift_nxt = 8'd0;
        end
      endcase
    end

    res.busy_res = (ph != PH_IDLE);

    case (ph)
      PH_RST_LOW:                seg_len = RST_LOW_LEN;
      PH_RST_REL:                seg_len = RELEASE_CHECK_TICKS;
      PH_RST_PRES:               seg_len = PRES_LEN;
      PH_RST_REC:                seg_len = RESET_RECOVER_TICKS;
      PH_WR_LOW, PH_RD_LOW:      seg_len = SLOT_LOW_TICKS;
      PH_WR_HOLD:                seg_len = WR_SLOT_LEN;
      PH_WR_REL:                 seg_len = WRITE_RELEASE_TICKS;
      PH_RD_WAIT:                seg_len = READ_SAMPLE_TICKS;
      PH_RD_REC:                 seg_len = RD_REC_LEN;
      default:                   seg_len = '0;
    endcase

    tick_wrap = tick_nxt + TICK_W'(1);
    seg_end = (tick_wrap >= seg_len);
    phase_nxt = ph;
    tick_nxt = seg_end ? '0 : tick_wrap;

    case (ph)
      PH_RST_LOW: begin
        res.drive_low = 1'b1;
        if (seg_end) phase_nxt = PH_RST_REL;
      end
      PH_RST_REL: begin
        if (seg_end) begin
          if (!in_line_level) begin
            status_nxt = STATUS_STUCK;
            res.done_res = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_RST_PRES;
          end
        end
      end
      PH_RST_PRES: begin
        if (seg_end) begin
          if (in_line_level) begin
            status_nxt = STATUS_ABSENT;
            res.done_res = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_RST_REC;
          end
        end
      end
      PH_RST_REC: begin
        if (seg_end) begin
          status_nxt = STATUS_PRESENT;
          res.done_res = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      PH_WR_LOW: begin
        res.drive_low = 1'b1;
        if (seg_end) phase_nxt = PH_WR_HOLD;
      end
      PH_WR_HOLD: begin
        res.drive_low = !shift_nxt[0];
        if (seg_end) phase_nxt = PH_WR_REL;
      end
      PH_WR_REL: begin
        if (seg_end) begin
          shift_nxt = {1'b0, shift_nxt[7:1]};
          if (bit_nxt == 3'd7) begin
            res.done_res = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            bit_nxt = bit_nxt + 3'd1;
            phase_nxt = PH_WR_LOW;
          end
        end
      end
      PH_RD_LOW: begin
        res.drive_low = 1'b1;
        if (seg_end) phase_nxt = PH_RD_WAIT;
      end
      PH_RD_WAIT: begin
        if (seg_end) begin
          shift_nxt = {in_line_level, shift_nxt[7:1]};
          phase_nxt = PH_RD_REC;
        end
      end
      PH_RD_REC: begin
        if (seg_end) begin
          if (bit_nxt == 3'd7) begin
            rdreg_nxt = shift_nxt;
            res.done_res = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            bit_nxt = bit_nxt + 3'd1;
            phase_nxt = PH_RD_LOW;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt = '0;
      end
    endcase

    res.status = status_nxt;
    res.read_result = rdreg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r <= '0;
      bit_r <= 3'd0;
      shift_r <= 8'd0;
      status_r <= STATUS_PRESENT;
      rdreg_r <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      tick_r <= tick_nxt;
      bit_r <= bit_nxt;
      shift_r <= shift_nxt;
      status_r <= status_nxt;
      rdreg_r <= rdreg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (accept) begin
        main_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive_low = main_r.drive_low;
  assign out_busy_res = main_r.busy_res;
  assign out_done_res = main_r.done_res;
  assign out_status = main_r.status;
  assign out_read_result = main_r.read_result;
  assign out_rejected = main_r.rejected;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
module testbench;
  import owbm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int QUIET_FROM = 150;
  localparam int QUIET_TO = 400;
  localparam int TICKS_PLANNED = 600;

  localparam logic [TICK_W-1:0] RST_LOW_LEN = TICK_W'(RESET_LOW_TICKS_DEF);
  localparam logic [TICK_W-1:0] PRES_LEN = TICK_W'(PRESENCE_SAMPLE_TICKS_DEF);
  localparam logic [TICK_W-1:0] HOLD_LEN = TICK_W'(WRITE_SLOT_TICKS_DEF);
  localparam logic [TICK_W-1:0] RD_REC_LEN = TICK_W'(READ_RECOVER_TICKS_DEF);

  localparam int REL_SAMPLE_AT = RESET_LOW_TICKS_DEF + int'(RELEASE_CHECK_TICKS) - 1;
  localparam int PRES_SAMPLE_AT = REL_SAMPLE_AT + PRESENCE_SAMPLE_TICKS_DEF;
  localparam int RESET_FULL_LEN = PRES_SAMPLE_AT + 1 + int'(RESET_RECOVER_TICKS);
  localparam int WRITE_BIT_LEN = int'(SLOT_LOW_TICKS) + WRITE_SLOT_TICKS_DEF
                                 + int'(WRITE_RELEASE_TICKS);
  localparam int READ_BIT_LEN = int'(SLOT_LOW_TICKS) + int'(READ_SAMPLE_TICKS)
                                + READ_RECOVER_TICKS_DEF;
  localparam int READ_SAMPLE_OFF = int'(SLOT_LOW_TICKS) + int'(READ_SAMPLE_TICKS) - 1;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] wbyte;
    logic       lvl;
    bit         drain;
  } bus_tick_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_command = CMD_NONE;
  logic [7:0] in_write_byte = 8'h00;
  logic       in_line_level = 1'b1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_drive_low;
  logic       out_busy_res;
  logic       out_done_res;
  logic [1:0] out_status;
  logic [7:0] out_read_result;
  logic       out_rejected;

  bus_tick_t tick_q[$];
  res_t expected_res_q[$];

  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cyc = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches = 0;

  int n_resets = 0, n_writes = 0, n_reads = 0, n_rejects = 0;
  int n_present = 0, n_stuck = 0, n_absent = 0;

  logic [PHASE_W-1:0] m_phase = PH_IDLE;
  logic [TICK_W-1:0]  m_cnt = '0;
  logic [2:0]         m_bit = '0;
  logic [7:0]         m_shift = '0;
  logic [1:0]         m_status = STATUS_PRESENT;
  logic [7:0]         m_rdbyte = '0;

  one_wire_bus_master_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_write_byte(in_write_byte),
    .in_line_level(in_line_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_drive_low(out_drive_low),
    .out_busy_res(out_busy_res),
    .out_done_res(out_done_res),
    .out_status(out_status),
    .out_read_result(out_read_result),
    .out_rejected(out_rejected)
  );

  always #4 clk = ~clk;

  function automatic bit count_tick(input logic [TICK_W-1:0] len);
    m_cnt = m_cnt + TICK_W'(1);
    if (m_cnt >= len) begin
      m_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void enter_phase(input logic [PHASE_W-1:0] ph);
    m_phase = ph;
    m_cnt = '0;
  endfunction

  function automatic res_t predict_bus_tick(input logic [1:0] cmd, input logic [7:0] wbyte,
                                            input logic lvl);
    res_t r;
    r = '0;
    if (m_phase != PH_IDLE) begin
      if (cmd != CMD_NONE) begin
        r.rejected = 1'b1;
        n_rejects++;
      end
    end else if (cmd != CMD_NONE) begin
      m_bit = '0;
      m_cnt = '0;
      case (cmd)
        CMD_RESET: begin
          m_phase = PH_RST_LOW;
          n_resets++;
        end
        CMD_WRITE: begin
          m_phase = PH_WR_LOW;
          m_shift = wbyte;
          n_writes++;
        end
        default: begin
          m_phase = PH_RD_LOW;
          m_shift = '0;
          n_reads++;
        end
      endcase
    end
    r.busy_res = (m_phase != PH_IDLE);
    case (m_phase)
      PH_RST_LOW: begin
        r.drive_low = 1'b1;
        if (count_tick(RST_LOW_LEN)) enter_phase(PH_RST_REL);
      end
      PH_RST_REL: begin
        if (count_tick(RELEASE_CHECK_TICKS)) begin
          if (!lvl) begin
            m_status = STATUS_STUCK;
            r.done_res = 1'b1;
            n_stuck++;
            enter_phase(PH_IDLE);
          end else begin
            enter_phase(PH_RST_PRES);
          end
        end
      end
      PH_RST_PRES: begin
        if (count_tick(PRES_LEN)) begin
          if (lvl) begin
            m_status = STATUS_ABSENT;
            r.done_res = 1'b1;
            n_absent++;
            enter_phase(PH_IDLE);
          end else begin
            enter_phase(PH_RST_REC);
          end
        end
      end
      PH_RST_REC: begin
        if (count_tick(RESET_RECOVER_TICKS)) begin
          m_status = STATUS_PRESENT;
          r.done_res = 1'b1;
          n_present++;
          enter_phase(PH_IDLE);
        end
      end
      PH_WR_LOW: begin
        r.drive_low = 1'b1;
        if (count_tick(SLOT_LOW_TICKS)) enter_phase(PH_WR_HOLD);
      end
      PH_WR_HOLD: begin
        r.drive_low = ~m_shift[0];
        if (count_tick(HOLD_LEN)) enter_phase(PH_WR_REL);
      end
      PH_WR_REL: begin
        if (count_tick(WRITE_RELEASE_TICKS)) begin
          m_shift = m_shift >> 1;
          if (m_bit == 3'd7) begin
            r.done_res = 1'b1;
            enter_phase(PH_IDLE);
          end else begin
            m_bit = m_bit + 3'd1;
            enter_phase(PH_WR_LOW);
          end
        end
      end
      PH_RD_LOW: begin
        r.drive_low = 1'b1;
        if (count_tick(SLOT_LOW_TICKS)) enter_phase(PH_RD_WAIT);
      end
      PH_RD_WAIT: begin
        if (count_tick(READ_SAMPLE_TICKS)) begin
          m_shift = {lvl, m_shift[7:1]};
          enter_phase(PH_RD_REC);
        end
      end
      PH_RD_REC: begin
        if (count_tick(RD_REC_LEN)) begin
          if (m_bit == 3'd7) begin
            m_rdbyte = m_shift;
            r.done_res = 1'b1;
            enter_phase(PH_IDLE);
          end else begin
            m_bit = m_bit + 3'd1;
            enter_phase(PH_RD_LOW);
          end
        end
      end
      default: begin
        enter_phase(PH_IDLE);
      end
    endcase
    r.status = m_status;
    r.read_result = m_rdbyte;
    return r;
  endfunction

  function automatic bit take_break();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 6;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s of result %0d is %0h, expected %0h",
                                name, results_seen, got, want));
  endtask

  task automatic queue_idle(input int n);
    bus_tick_t t;
    for (int i = 0; i < n; i++) begin
      t.cmd = CMD_NONE;
      t.wbyte = 8'($urandom_range(0, 255));
      t.lvl = 1'($urandom_range(0, 1));
      t.drain = 1'b0;
      tick_q.push_back(t);
    end
  endtask

  // The line levels at the sampling ticks are set so that the command takes the wanted path.
  task automatic queue_command(input logic [1:0] cmd, input logic [7:0] data,
                               input logic [1:0] outcome, input bit drain,
                               input int noise_pct, input bit hit_last);
    bus_tick_t t;
    int len;
    case (cmd)
      CMD_RESET: begin
        if (outcome == STATUS_STUCK) len = REL_SAMPLE_AT + 1;
        else if (outcome == STATUS_ABSENT) len = PRES_SAMPLE_AT + 1;
        else len = RESET_FULL_LEN;
      end
      CMD_WRITE: len = 8 * WRITE_BIT_LEN;
      default: len = 8 * READ_BIT_LEN;
    endcase
    for (int off = 0; off < len; off++) begin
      t.cmd = CMD_NONE;
      t.wbyte = 8'($urandom_range(0, 255));
      t.lvl = 1'($urandom_range(0, 1));
      t.drain = 1'b0;
      if (off == 0) begin
        t.cmd = cmd;
        t.drain = drain;
        if (cmd == CMD_WRITE) t.wbyte = data;
      end else if ((hit_last && off == len - 1) || $urandom_range(0, 99) < noise_pct) begin
        t.cmd = 2'($urandom_range(1, 3));
      end
      if (cmd == CMD_RESET && off == REL_SAMPLE_AT) t.lvl = (outcome != STATUS_STUCK);
      if (cmd == CMD_RESET && off == PRES_SAMPLE_AT) t.lvl = (outcome == STATUS_ABSENT);
      if (cmd == CMD_READ && off % READ_BIT_LEN == READ_SAMPLE_OFF)
        t.lvl = data[off / READ_BIT_LEN];
      tick_q.push_back(t);
    end
  endtask

  always @(posedge clk) begin : drive_proc
    bus_tick_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_res_q.push_back(predict_bus_tick(in_command, in_write_byte, in_line_level));
        ticks_sent <= ticks_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (tick_q.size() > 0 && !take_break()
            && !(tick_q[0].drain && (in_valid || ticks_sent != results_seen))) begin
          item = tick_q.pop_front();
          in_valid <= 1'b1;
          in_command <= item.cmd;
          in_write_byte <= item.wbyte;
          in_line_level <= item.lvl;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor_proc
    res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_res_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_res_q.pop_front();
          check_field("drive_low", 8'(out_drive_low), 8'(want.drive_low));
          check_field("busy_res", 8'(out_busy_res), 8'(want.busy_res));
          check_field("done_res", 8'(out_done_res), 8'(want.done_res));
          check_field("status", 8'(out_status), 8'(want.status));
          check_field("read_result", out_read_result, want.read_result);
          check_field("rejected", 8'(out_rejected), 8'(want.rejected));
        end
      end
      out_ready <= !take_break();
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    queue_idle(2);
    queue_command(CMD_RESET, 8'h00, STATUS_STUCK, 1'b0, 2, 1'b1);
    queue_idle(1);
    queue_command(CMD_WRITE, 8'hA5, STATUS_PRESENT, 1'b1, 2, 1'b0);
    // The write is cut short so that the run stays near the planned number of ticks.
    while (tick_q.size() > TICKS_PLANNED) void'(tick_q.pop_back());

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (tick_q.size() != 0 || in_valid || ticks_sent != results_seen);
    repeat (10) @(posedge clk);

    if (expected_res_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_res_q.size()));

    $display("Covered %0d bus resets (%0d with presence, %0d stuck low, %0d without presence),",
             n_resets, n_present, n_stuck, n_absent);
    $display("%0d byte writes, %0d byte reads, %0d commands turned away while busy; %0d ticks.",
             n_writes, n_reads, n_rejects, results_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/owbm_pkg.sv
hw/rtl/one_wire_bus_master_core.sv
sim/testbench.sv
